@@ rtl/txr_pkg.sv @@
// ----------------------------------------------------------------------------
// txr_pkg: shared definitions for the transmit descriptor ring producer
// Widths, codes and the queue entry format used by front, queue and back.
// ----------------------------------------------------------------------------
package txr_pkg;

  localparam int IDX_W          = 12;
  localparam int LEN_W          = 16;
  localparam int HEAD_W         = 12;
  localparam int OP_W           = 2;
  localparam int STATUS_W       = 3;
  localparam int ADDR_W         = 64;
  localparam int CMD_W          = 64;
  localparam int CFG_LOG2_W     = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 1;

  localparam int MAX_RING_LOG2  = 12;
  localparam int BUFFER_BYTES   = 2048;
  localparam int MIN_PACKET_LEN = 17;
  localparam int CMD_SHIFT      = 4;
  localparam int LEN_SHIFT      = 34;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [3:0]            CMD_FLAGS       = 4'h5;  // EOP | ICRC
  localparam logic [CFG_LOG2_W-1:0] RING_LOG2_RESET = 4'd9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BASE    = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_SEND     = 2'd0,
    OP_HEAD     = 2'd1,
    OP_DOORBELL = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WRITTEN   = 3'd0,
    ST_UNDERSIZE = 3'd1,
    ST_OVERSIZE  = 3'd2,
    ST_FULL      = 3'd3,
    ST_DOORBELL  = 3'd4,
    ST_HEAD      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    LEN_OK    = 2'd0,
    LEN_SHORT = 2'd1,
    LEN_LONG  = 2'd2
  } len_class_t;

  typedef struct packed {
    op_t                kind;
    len_class_t         len_class;
    logic [LEN_W-1:0]   packet_length;
    logic [HEAD_W-1:0]  hardware_head;
  } entry_t;

endpackage

@@ rtl/txr_in_if.sv @@
// ----------------------------------------------------------------------------
// txr_in_if: request channel of the descriptor ring producer
// Valid/ready channel carrying one packet, head or doorbell request.
// ----------------------------------------------------------------------------
interface txr_in_if;
  logic                        valid;
  logic                        ready;
  logic [txr_pkg::OP_W-1:0]    op;
  logic [txr_pkg::LEN_W-1:0]   packet_length;
  logic [txr_pkg::HEAD_W-1:0]  hardware_head;

  modport source (output valid, output op, output packet_length,
                  output hardware_head, input ready);
  modport sink   (input valid, input op, input packet_length,
                  input hardware_head, output ready);
endinterface

@@ rtl/txr_out_if.sv @@
// ----------------------------------------------------------------------------
// txr_out_if: result channel of the descriptor ring producer
// Valid/ready channel carrying one status and descriptor words per request.
// ----------------------------------------------------------------------------
interface txr_out_if;
  logic                          valid;
  logic                          ready;
  logic [txr_pkg::STATUS_W-1:0]  status;
  logic [txr_pkg::IDX_W-1:0]     slot_index;
  logic [txr_pkg::ADDR_W-1:0]    buffer_address;
  logic [txr_pkg::CMD_W-1:0]     command_word;

  modport source (output valid, output status, output slot_index,
                  output buffer_address, output command_word, input ready);
  modport sink   (input valid, input status, input slot_index,
                  input buffer_address, input command_word, output ready);
endinterface

@@ rtl/tx_descriptor_ring_producer.sv @@
// ----------------------------------------------------------------------------
// tx_descriptor_ring_producer: producer side of one transmit descriptor ring
// Decode front, short queue and ring update back, plus configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request transfers. op selects send (with packet_length), head
//            update (with hardware_head) or doorbell. The reserved op is taken
//            and produces no result.
//   out_ch : one result transfer per request: status, slot index and the two
//            descriptor words (zero where the status carries none).
//   cfg_*  : write-only registers (ring size log2, buffer base address);
//            write them only while no request is in flight.
// Throughput: one request per cycle sustained while out_ch.ready stays high;
//   a low out_ch.ready stalls the result register and then the queue. A
//   request passes through the decoupling queue and then the result
//   register, which drives out_ch.valid. The ring update loop (free-slot
//   check and tail increment) sets the rate.
// Reset (synchronous, rst_n low): tail and head go to 0, the queue empties,
//   ring size log2 returns to 9 and the base address to 0.
// Stalls: when out_ch.ready is low the result holds in its register; the queue
//   (four entries) keeps taking requests until it fills, then in_ch.ready drops.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_producer #(
  parameter int BUFFER_BYTES = txr_pkg::BUFFER_BYTES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  txr_in_if.sink                           in_ch,
  txr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [txr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [txr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  logic [txr_pkg::CFG_LOG2_W-1:0]  ring_size_log2_r, ring_size_log2_nxt;
  logic [txr_pkg::ADDR_W-1:0]      buffer_base_r, buffer_base_nxt;

  // front to queue
  logic             push_valid, push_ready;
  txr_pkg::entry_t  push_data;

  // queue to back
  logic             pop_valid, pop_ready;
  txr_pkg::entry_t  pop_data;

  always_comb begin
    ring_size_log2_nxt = ring_size_log2_r;
    buffer_base_nxt    = buffer_base_r;
    if (cfg_we) begin
      case (cfg_index)
        txr_pkg::CFG_RING_SIZE_LOG2:
          ring_size_log2_nxt = cfg_wdata[txr_pkg::CFG_LOG2_W-1:0];
        txr_pkg::CFG_BUFFER_BASE:
          buffer_base_nxt = cfg_wdata[txr_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_log2_r <= txr_pkg::RING_LOG2_RESET;
      buffer_base_r    <= '0;
    end else begin
      ring_size_log2_r <= ring_size_log2_nxt;
      buffer_base_r    <= buffer_base_nxt;
    end
  end

  // decode: drop reserved ops, pre-classify length
  txr_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decoupling queue so decode and ring update stall independently
  txr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // ring state, descriptor build and result register
  txr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ring_size_log2 (ring_size_log2_r),
    .buffer_base    (buffer_base_r),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_ch         (out_ch)
  );

endmodule

@@ rtl/txr_front.sv @@
// ----------------------------------------------------------------------------
// txr_front: request decode
// Takes requests, drops reserved ops, classifies packet length.
// ----------------------------------------------------------------------------
module txr_front #(
  parameter int BUFFER_BYTES = txr_pkg::BUFFER_BYTES
) (
  txr_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output txr_pkg::entry_t push_data
);

  logic known_op;

  always_comb begin
    known_op = in_ch.op inside {txr_pkg::OP_SEND, txr_pkg::OP_HEAD, txr_pkg::OP_DOORBELL};

    push_data.kind          = txr_pkg::op_t'(in_ch.op);
    push_data.packet_length = in_ch.packet_length;
    push_data.hardware_head = in_ch.hardware_head;
    if (in_ch.packet_length < txr_pkg::LEN_W'(txr_pkg::MIN_PACKET_LEN)) begin
      push_data.len_class = txr_pkg::LEN_SHORT;
    end else if (in_ch.packet_length > txr_pkg::LEN_W'(BUFFER_BYTES)) begin
      push_data.len_class = txr_pkg::LEN_LONG;
    end else begin
      push_data.len_class = txr_pkg::LEN_OK;
    end
  end

  // reserved op is taken and discarded here
  assign push_valid  = in_ch.valid && known_op;
  assign in_ch.ready = push_ready;

endmodule

@@ rtl/txr_queue.sv @@
// ----------------------------------------------------------------------------
// txr_queue: decoupling queue
// Small register FIFO between request decode and ring update.
// ----------------------------------------------------------------------------
module txr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  txr_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output txr_pkg::entry_t pop_data
);

  localparam int DEPTH = txr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  txr_pkg::entry_t   entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == $past(count_r) + CNT_W'($past(push)) - CNT_W'($past(pop)))
    else $error("queue count lost track of transfers");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (rd_ptr_r == wr_ptr_r))
    else $error("empty queue with pointers apart");
`endif

endmodule

@@ rtl/txr_back.sv @@
// ----------------------------------------------------------------------------
// txr_back: ring update and result register
// Holds tail/head, checks free slots, builds descriptors, drives results.
// ----------------------------------------------------------------------------
module txr_back #(
  parameter int BUFFER_BYTES = txr_pkg::BUFFER_BYTES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [txr_pkg::CFG_LOG2_W-1:0]    ring_size_log2,
  input  logic [txr_pkg::ADDR_W-1:0]        buffer_base,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  txr_pkg::entry_t                   pop_data,
  txr_out_if.source                         out_ch
);

  localparam int IDX_W  = txr_pkg::IDX_W;
  localparam int PROD_W = IDX_W + $clog2(BUFFER_BYTES + 1);

  logic [IDX_W-1:0]                 tail_r, tail_nxt;
  logic [IDX_W-1:0]                 head_r, head_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [txr_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic [IDX_W-1:0]                 slot_r, slot_nxt;
  logic [txr_pkg::ADDR_W-1:0]       addr_r, addr_nxt;
  logic [txr_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;

  logic [txr_pkg::CFG_LOG2_W-1:0]   lg;
  logic [IDX_W-1:0]                 mask;
  logic [IDX_W-1:0]                 tail, head, free_slots;
  logic [PROD_W-1:0]                offset;
  txr_pkg::status_t                 st;
  logic                             pop;

  // clamp ring size and mask indices to it
  always_comb begin
    if (ring_size_log2 == '0) begin
      lg = txr_pkg::CFG_LOG2_W'(1);
    end else if (ring_size_log2 > txr_pkg::CFG_LOG2_W'(txr_pkg::MAX_RING_LOG2)) begin
      lg = txr_pkg::CFG_LOG2_W'(txr_pkg::MAX_RING_LOG2);
    end else begin
      lg = ring_size_log2;
    end
    mask       = IDX_W'(((IDX_W+1)'(1) << lg) - (IDX_W+1)'(1));
    tail       = tail_r & mask;
    head       = head_r & mask;
    free_slots = (mask - tail + head) & mask;
    offset     = PROD_W'(tail) * PROD_W'(BUFFER_BYTES);
  end

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    case (pop_data.kind)
      txr_pkg::OP_SEND: begin
        if (free_slots == '0) begin
          st = txr_pkg::ST_FULL;
        end else if (pop_data.len_class == txr_pkg::LEN_SHORT) begin
          st = txr_pkg::ST_UNDERSIZE;
        end else if (pop_data.len_class == txr_pkg::LEN_LONG) begin
          st = txr_pkg::ST_OVERSIZE;
        end else begin
          st = txr_pkg::ST_WRITTEN;
        end
      end
      txr_pkg::OP_HEAD:     st = txr_pkg::ST_HEAD;
      txr_pkg::OP_DOORBELL: st = txr_pkg::ST_DOORBELL;
      default:              st = txr_pkg::ST_HEAD;
    endcase
  end

  always_comb begin
    tail_nxt      = tail_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    addr_nxt      = addr_r;
    cmd_nxt       = cmd_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      status_nxt    = st;
      slot_nxt      = '0;
      addr_nxt      = '0;
      cmd_nxt       = '0;
      case (st)
        txr_pkg::ST_WRITTEN: begin
          slot_nxt = tail;
          addr_nxt = buffer_base + txr_pkg::ADDR_W'(offset);
          cmd_nxt  = (txr_pkg::CMD_W'(txr_pkg::CMD_FLAGS) << txr_pkg::CMD_SHIFT) |
                     (txr_pkg::CMD_W'(pop_data.packet_length) << txr_pkg::LEN_SHIFT);
          tail_nxt = (tail + IDX_W'(1)) & mask;
        end
        txr_pkg::ST_DOORBELL: slot_nxt = tail;
        txr_pkg::ST_HEAD:     head_nxt = pop_data.hardware_head;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_r      <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tail_r      <= tail_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    addr_r   <= addr_nxt;
    cmd_r    <= cmd_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.slot_index     = slot_r;
  assign out_ch.buffer_address = addr_r;
  assign out_ch.command_word   = cmd_r;

`ifndef NO_ASSERTIONS
  a_tail_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && st == txr_pkg::ST_WRITTEN) |=>
      tail_r == (($past(tail) + IDX_W'(1)) & $past(mask)))
    else $error("tail did not advance after descriptor write");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && st == txr_pkg::ST_FULL) |=> $stable(tail_r) && $stable(head_r))
    else $error("ring state moved on refused transfer");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == txr_pkg::ST_WRITTEN) |->
      (cmd_r[txr_pkg::LEN_SHIFT +: txr_pkg::LEN_W] >=
         txr_pkg::LEN_W'(txr_pkg::MIN_PACKET_LEN)) &&
      (cmd_r[txr_pkg::LEN_SHIFT +: txr_pkg::LEN_W] <= txr_pkg::LEN_W'(BUFFER_BYTES)))
    else $error("descriptor written with out of range length");
`endif

endmodule

@@ sim/txr_descriptor_checker.sv @@
// ----------------------------------------------------------------------------
// txr_descriptor_checker: predicts and checks descriptor ring results
// Watches the request, result and register ports, keeps its own ring state
// and compares every result transfer with the oldest expected descriptor.
// ----------------------------------------------------------------------------
module txr_descriptor_checker
  import txr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_W-1:0]       in_op,
  input  logic [LEN_W-1:0]      in_packet_length,
  input  logic [HEAD_W-1:0]     in_hardware_head,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [IDX_W-1:0]      out_slot_index,
  input  logic [ADDR_W-1:0]     out_buffer_address,
  input  logic [CMD_W-1:0]      out_command_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           error_count,
  output int unsigned           descriptors_outstanding,
  output int unsigned           written_count,
  output int unsigned           full_count,
  output int unsigned           drop_count
);

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [ADDR_W-1:0]  addr;
    logic [CMD_W-1:0]   cmd;
  } descriptor_t;

  descriptor_t pending_descriptors [$];

  logic [IDX_W-1:0]      tail_q;
  logic [IDX_W-1:0]      head_q;
  logic [CFG_LOG2_W-1:0] ring_log2;
  logic [ADDR_W-1:0]     buffer_base;
  int unsigned           errors;
  int unsigned           written;
  int unsigned           refused;
  int unsigned           dropped;

  // ring size is clamped to 1..MAX_RING_LOG2
  function automatic logic [IDX_W-1:0] slot_mask();
    int unsigned lg;
    lg = ring_log2;
    if (lg < 1) lg = 1;
    if (lg > MAX_RING_LOG2) lg = MAX_RING_LOG2;
    return IDX_W'((1 << lg) - 1);
  endfunction

  // returns 0 for the reserved op, which is swallowed without a result
  function automatic bit predict_descriptor(input logic [OP_W-1:0] op,
                                            input logic [LEN_W-1:0] len,
                                            input logic [HEAD_W-1:0] hw_head,
                                            output descriptor_t res);
    logic [IDX_W-1:0] mask;
    logic [IDX_W-1:0] tail;
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] free_slots;
    mask = slot_mask();
    tail = tail_q & mask;
    head = head_q & mask;
    res  = '0;
    case (op)
      OP_SEND: begin
        // full check wins over the length checks
        free_slots = (mask - tail + head) & mask;
        if (free_slots == '0) res.status = ST_FULL;
        else if (len < MIN_PACKET_LEN) res.status = ST_UNDERSIZE;
        else if (len > BUFFER_BYTES) res.status = ST_OVERSIZE;
        else begin
          res.status = ST_WRITTEN;
          res.slot   = tail;
          res.addr   = buffer_base + ADDR_W'(tail) * ADDR_W'(BUFFER_BYTES);
          res.cmd    = (CMD_W'(CMD_FLAGS) << CMD_SHIFT) | (CMD_W'(len) << LEN_SHIFT);
          tail_q     = (tail + 1'b1) & mask;
        end
        return 1'b1;
      end
      OP_HEAD: begin
        head_q     = hw_head;
        res.status = ST_HEAD;
        return 1'b1;
      end
      OP_DOORBELL: begin
        res.status = ST_DOORBELL;
        res.slot   = tail;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    descriptor_t want;
    descriptor_t fresh;
    if (!rst_n) begin
      tail_q      = '0;
      head_q      = '0;
      ring_log2   = RING_LOG2_RESET;
      buffer_base = '0;
      errors      = 0;
      written     = 0;
      refused     = 0;
      dropped     = 0;
      pending_descriptors.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_descriptors.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, expected none, actual status %0d",
                   $time, out_status);
        end else begin
          want = pending_descriptors.pop_front();
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("slot_index", 64'(want.slot), 64'(out_slot_index));
          check_field("buffer_address", want.addr, out_buffer_address);
          check_field("command_word", want.cmd, out_command_word);
          case (want.status)
            ST_WRITTEN:                 written++;
            ST_FULL:                    refused++;
            ST_UNDERSIZE, ST_OVERSIZE:  dropped++;
            default: ;
          endcase
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RING_SIZE_LOG2: ring_log2   = cfg_wdata[CFG_LOG2_W-1:0];
          CFG_BUFFER_BASE:    buffer_base = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_descriptor(in_op, in_packet_length, in_hardware_head, fresh))
          pending_descriptors.push_back(fresh);
      end
    end
    error_count             <= errors;
    descriptors_outstanding <= pending_descriptors.size();
    written_count           <= written;
    full_count              <= refused;
    drop_count              <= dropped;
  end

endmodule

@@ sim/tb_tx_descriptor_ring_producer.sv @@
// ----------------------------------------------------------------------------
// tb_tx_descriptor_ring_producer: testbench for the descriptor ring producer
// Directed requests over the length limits, ring full and address wrap, then
// random phases across clamped and unclamped ring sizes and base addresses,
// with random gaps on both channels. Checking lives in txr_descriptor_checker.
// ----------------------------------------------------------------------------
module tb_tx_descriptor_ring_producer;
  import txr_pkg::*;

  // op code the block takes and ignores
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam int PHASES             = 12;
  localparam int REQUESTS_PER_PHASE = 78;
  // cycles with no transfer on either channel before we give up
  localparam int IDLE_LIMIT         = 2000;
  // spare cycles after the last result before the registers are touched
  localparam int SETTLE_CYCLES      = 6;

  // ring sizes per random phase: 0, 13 and 15 exercise the clamp
  localparam logic [CFG_LOG2_W-1:0] PHASE_LOG2 [PHASES] =
    '{4'd1, 4'd2, 4'd0, 4'd3, 4'd15, 4'd4, 4'd12, 4'd1, 4'd13, 4'd2, 4'd5, 4'd9};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  txr_in_if  in_ch ();
  txr_out_if out_ch ();

  int unsigned error_count;
  int unsigned descriptors_outstanding;
  int unsigned written_count;
  int unsigned full_count;
  int unsigned drop_count;
  int unsigned requests_sent;
  int unsigned idle_cycles;
  bit          steady;  // sender runs back to back in this phase

  tx_descriptor_ring_producer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  txr_descriptor_checker checker_i (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_ch.valid),
    .in_ready                (in_ch.ready),
    .in_op                   (in_ch.op),
    .in_packet_length        (in_ch.packet_length),
    .in_hardware_head        (in_ch.hardware_head),
    .out_valid               (out_ch.valid),
    .out_ready               (out_ch.ready),
    .out_status              (out_ch.status),
    .out_slot_index          (out_ch.slot_index),
    .out_buffer_address      (out_ch.buffer_address),
    .out_command_word        (out_ch.command_word),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .error_count             (error_count),
    .descriptors_outstanding (descriptors_outstanding),
    .written_count           (written_count),
    .full_count              (full_count),
    .drop_count              (drop_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(input bit no_gaps);
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One request transfer. valid stays high into the next call when no gap
  // follows, so it is never dropped and raised in the same step.
  task automatic push_request(input logic [OP_W-1:0]   op,
                              input logic [LEN_W-1:0]  len,
                              input logic [HEAD_W-1:0] hw_head);
    int unsigned gap;
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.packet_length <= len;
    in_ch.hardware_head <= hw_head;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
    gap = pick_gap(steady);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every expected result has been returned, then
  // leave a few quiet cycles.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (descriptors_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Result side back-pressure: ready runs of random length broken by stalls.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = pick_gap(1'b0);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned       roll;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    logic [HEAD_W-1:0] hw_head;
    logic [ADDR_W-1:0] base;
    logic [63:0]       log2_word;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_SEND;
    in_ch.packet_length <= '0;
    in_ch.hardware_head <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_RING_SIZE_LOG2;
    cfg_wdata           <= '0;
    steady              = 1'b0;
    requests_sent       = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset settings: 512-entry ring at base 0 ---
    push_request(OP_DOORBELL, '0, '0);                     // tail still 0
    push_request(OP_SEND, LEN_W'(MIN_PACKET_LEN), '0);      // shortest legal
    push_request(OP_SEND, LEN_W'(MIN_PACKET_LEN - 1), '0);  // one below: undersize
    push_request(OP_SEND, '0, '0);                          // zero length
    push_request(OP_SEND, LEN_W'(BUFFER_BYTES), '0);        // fills the buffer exactly
    push_request(OP_SEND, LEN_W'(BUFFER_BYTES + 1), '0);    // one over: oversize
    push_request(OP_SEND, '1, '0);                          // largest length field
    push_request(OP_HEAD, '0, '1);                          // head beyond the ring, masked
    push_request(OP_SEND, LEN_W'(100), '0);
    push_request(OP_RESERVED, '1, '1);                      // swallowed, no result
    push_request(OP_DOORBELL, '0, '0);
    wait_idle();

    // --- directed, two-entry ring near the top of the address space ---
    // Old tail and head are both masked down to 1, so one slot is free and
    // the address of slot 1 wraps past 2^64.
    write_reg(CFG_RING_SIZE_LOG2, 64'd1);
    write_reg(CFG_BUFFER_BASE, 64'hFFFF_FFFF_FFFF_FC00);
    push_request(OP_SEND, LEN_W'(1500), '0);
    push_request(OP_SEND, LEN_W'(5), '0);                   // full beats undersize
    push_request(OP_SEND, LEN_W'(3000), '0);                // full beats oversize
    push_request(OP_SEND, LEN_W'(64), '0);                  // full, legal length
    push_request(OP_HEAD, '0, '0);                          // frees one slot
    push_request(OP_SEND, LEN_W'(BUFFER_BYTES), '0);        // written to slot 0, tail moves to 1
    push_request(OP_DOORBELL, '0, '0);
    push_request(OP_SEND, LEN_W'(MIN_PACKET_LEN), '0);      // full again

    // --- random phases ---
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      log2_word = {$urandom, $urandom};          // upper bits are don't care
      log2_word[CFG_LOG2_W-1:0] = PHASE_LOG2[phase];
      if (phase == 0) base = '1;
      else if (phase == 1) base = '0;
      else base = {$urandom, $urandom};
      write_reg(CFG_RING_SIZE_LOG2, log2_word);
      if (phase != 5) write_reg(CFG_BUFFER_BASE, base);   // one phase keeps the old base
      steady = ($urandom_range(0, 3) == 0);

      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        // sender holds off mid-phase until the result side has caught up
        if (n == REQUESTS_PER_PHASE / 2 && (phase % 3 == 0 || $urandom_range(0, 1) == 1))
          wait_idle();

        roll = $urandom_range(0, 99);
        if (roll < 68)      op = OP_SEND;
        else if (roll < 84) op = OP_HEAD;
        else if (roll < 95) op = OP_DOORBELL;
        else                op = OP_RESERVED;

        roll = $urandom_range(0, 99);
        if (roll < 70)      len = LEN_W'($urandom_range(MIN_PACKET_LEN, BUFFER_BYTES));
        else if (roll < 80) len = LEN_W'($urandom_range(0, MIN_PACKET_LEN - 1));
        else if (roll < 90) len = LEN_W'($urandom_range(BUFFER_BYTES + 1, 65535));
        else if (roll < 95) len = LEN_W'($urandom);
        else begin
          case ($urandom_range(0, 3))
            0:       len = LEN_W'(MIN_PACKET_LEN - 1);
            1:       len = LEN_W'(MIN_PACKET_LEN);
            2:       len = LEN_W'(BUFFER_BYTES);
            default: len = LEN_W'(BUFFER_BYTES + 1);
          endcase
        end
        hw_head = HEAD_W'($urandom);
        push_request(op, len, hw_head);
      end
    end

    // drain: every result back, then a few spare cycles for stray transfers
    steady = 1'b0;
    wait_idle();

    $display("Run covered %0d requests over %0d ring settings, clamped sizes included;",
             requests_sent, PHASES + 2);
    $display("%0d descriptors written, %0d refused on a full ring, %0d dropped on length.",
             written_count, full_count, drop_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/txr_pkg.sv
rtl/txr_in_if.sv
rtl/txr_out_if.sv
rtl/txr_front.sv
rtl/txr_queue.sv
rtl/txr_back.sv
rtl/tx_descriptor_ring_producer.sv
sim/txr_descriptor_checker.sv
sim/tb_tx_descriptor_ring_producer.sv
